[hw/rtl/krt_pkg.sv]
// ----------------------------------------------------------------------------
// krt_pkg: shared definitions for the keyed record table
// Field widths, command and status codes, and the stored record layout.
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int unsigned DepthDefault = 32;

  localparam int unsigned KindW   = 3;
  localparam int unsigned KeyW    = 16;
  localparam int unsigned TextW   = 64;
  localparam int unsigned AmountW = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW    = 6;

  typedef enum logic [KindW-1:0] {
    K_INSERT = 3'd0,
    K_SEARCH = 3'd1,
    K_UPDATE = 3'd2,
    K_DELETE = 3'd3,
    K_LIST   = 3'd4
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_DUP  = 2'd2,
    ST_MISS = 2'd3
  } status_e;

  // One table entry as it sits in the record memory.
  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [TextW-1:0]   name;
    logic [AmountW-1:0] amount;
    logic [TextW-1:0]   stamp;
  } rec_t;

  localparam int unsigned RecW = $bits(rec_t);

endpackage

[hw/rtl/krt_ram.sv]
// ----------------------------------------------------------------------------
// krt_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module krt_ram #(
  parameter int unsigned WIDTH = krt_pkg::RecW,
  parameter int unsigned DEPTH = krt_pkg::DepthDefault,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/keyed_record_table.sv]
// ----------------------------------------------------------------------------
// keyed_record_table: insertion-ordered table of keyed records
// Insert, search, update, delete and list over up to DEPTH records held in
// one record memory, walked by a linear search sequencer.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                        Handshake
//  -------   --------------------------------------------   -------------------
//  command   kind_i key_i name_text_i amount_i time_text_i  start_i & !busy_o
//  result    status_o out_key_o out_name_o out_amount_o     res_valid_o, one
//            out_time_o occupancy_o last_o                  cycle, no stall
//
// Sequencing: search, update, insert and delete walk the record memory, one
// entry per cycle, through the single read port, until a match or the end of
// the held records. A found delete reports the removed record at once and
// then shifts each later record down, one per cycle. List gives one result
// per cycle, each from a registered read of the memory. Refused inserts on a
// full table, lists of an empty table and unused kinds answer without walking
// the memory.
// Reset clears the record count and the sequencer state; memory contents are never cleared since
// no entry at or above the count is ever read. The receiver cannot stall:
// each result is presented for exactly one cycle.
module keyed_record_table #(
  parameter int unsigned DEPTH = krt_pkg::DepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [krt_pkg::KindW-1:0]   kind_i,
  input  logic [krt_pkg::KeyW-1:0]    key_i,
  input  logic [krt_pkg::TextW-1:0]   name_text_i,
  input  logic [krt_pkg::AmountW-1:0] amount_i,
  input  logic [krt_pkg::TextW-1:0]   time_text_i,
  output logic                        res_valid_o,
  output logic [krt_pkg::StatusW-1:0] status_o,
  output logic [krt_pkg::KeyW-1:0]    out_key_o,
  output logic [krt_pkg::TextW-1:0]   out_name_o,
  output logic [krt_pkg::AmountW-1:0] out_amount_o,
  output logic [krt_pkg::TextW-1:0]   out_time_o,
  output logic [krt_pkg::OccW-1:0]    occupancy_o,
  output logic                        last_o
);

  // AW addresses an entry; CW counts records up to and including DEPTH.
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_LIST
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] held_q, held_d;
  // cnt_q is the next address to read: the search cursor, the shift source or
  // the list cursor. pidx_q is the in-flight read address, less one in a shift.
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] pidx_q, pidx_d;
  logic          pend_q, pend_d;
  logic          res_valid_q, res_valid_d;

  // Latched command.
  logic [krt_pkg::KindW-1:0]   kind_q;
  logic [krt_pkg::KeyW-1:0]    key_q;
  logic [krt_pkg::TextW-1:0]   name_q;
  logic [krt_pkg::AmountW-1:0] amount_q;
  logic [krt_pkg::TextW-1:0]   stamp_q;
  logic                        cmd_load;

  // Result registers.
  krt_pkg::status_e         status_q, status_d;
  krt_pkg::rec_t            res_rec_q, res_rec_d;
  logic [krt_pkg::OccW-1:0] occ_q, occ_d;
  logic                     last_q, last_d;

  // Memory port.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  krt_pkg::rec_t ram_wdata, rd_rec;
  logic [krt_pkg::RecW-1:0] ram_rdata;

  logic          hit;
  logic [CW-1:0] pidx_ext;
  logic [CW-1:0] cnt_dec;
  krt_pkg::rec_t new_rec;

  krt_ram #(
    .WIDTH (krt_pkg::RecW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_rec   = krt_pkg::rec_t'(ram_rdata);
  assign hit      = pend_q && (rd_rec.key == key_q);
  assign pidx_ext = CW'(pidx_q);
  assign cnt_dec  = cnt_q - CW'(1);

  // The record an insert stores, or an update leaves behind.
  assign new_rec = '{key: key_q, name: name_q, amount: amount_q, stamp: stamp_q};

  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    cnt_d       = cnt_q;
    pidx_d      = pidx_q;
    pend_d      = 1'b0;
    res_valid_d = 1'b0;
    status_d    = krt_pkg::ST_MISS;
    res_rec_d   = '0;
    occ_d       = krt_pkg::OccW'(held_q);
    last_d      = 1'b1;
    cmd_load    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_load = 1'b1;
          cnt_d    = '0;
          case (kind_i)
            krt_pkg::K_INSERT: begin
              // A full table is refused before any search.
              if (held_q >= CW'(DEPTH)) begin
                res_valid_d = 1'b1;
                status_d    = krt_pkg::ST_FULL;
              end else begin
                state_d = S_SCAN;
              end
            end
            krt_pkg::K_SEARCH, krt_pkg::K_UPDATE, krt_pkg::K_DELETE: begin
              state_d = S_SCAN;
            end
            krt_pkg::K_LIST: begin
              if (held_q == '0) begin
                res_valid_d = 1'b1;
              end else begin
                state_d = S_LIST;
              end
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          state_d     = S_IDLE;
          res_valid_d = 1'b1;
          status_d    = krt_pkg::ST_OK;
          case (kind_q)
            krt_pkg::K_INSERT: begin
              status_d = krt_pkg::ST_DUP;
            end
            krt_pkg::K_SEARCH: begin
              res_rec_d = rd_rec;
            end
            krt_pkg::K_UPDATE: begin
              ram_we    = 1'b1;
              ram_waddr = pidx_q;
              ram_wdata = new_rec;
              res_rec_d = new_rec;
            end
            krt_pkg::K_DELETE: begin
              // Report the removed record now, then close the gap.
              res_rec_d = rd_rec;
              occ_d     = krt_pkg::OccW'(held_q - CW'(1));
              cnt_d     = pidx_ext + CW'(1);
              state_d   = S_SHIFT;
            end
            default: begin
              status_d = krt_pkg::ST_MISS;
            end
          endcase
        end else if (cnt_q < held_q) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_q[AW-1:0];
          pend_d    = 1'b1;
          pidx_d    = cnt_q[AW-1:0];
          cnt_d     = cnt_q + CW'(1);
        end else begin
          state_d     = S_IDLE;
          res_valid_d = 1'b1;
          if (kind_q == krt_pkg::K_INSERT) begin
            // No duplicate found: append at the end.
            ram_we    = 1'b1;
            ram_waddr = held_q[AW-1:0];
            ram_wdata = new_rec;
            held_d    = held_q + CW'(1);
            status_d  = krt_pkg::ST_OK;
            res_rec_d = new_rec;
            occ_d     = krt_pkg::OccW'(held_q + CW'(1));
          end
        end
      end

      S_SHIFT: begin
        // Entry cnt is read while the one read before it is written one down.
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pidx_q;
          ram_wdata = rd_rec;
        end
        if (cnt_q < held_q) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_q[AW-1:0];
          pend_d    = 1'b1;
          pidx_d    = cnt_dec[AW-1:0];
          cnt_d     = cnt_q + CW'(1);
        end else begin
          held_d  = held_q - CW'(1);
          state_d = S_IDLE;
        end
      end

      S_LIST: begin
        if (pend_q) begin
          res_valid_d = 1'b1;
          status_d    = krt_pkg::ST_OK;
          res_rec_d   = rd_rec;
          last_d      = (pidx_ext + CW'(1)) == held_q;
          if (last_d) begin
            state_d = S_IDLE;
          end
        end
        if (cnt_q < held_q) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_q[AW-1:0];
          pend_d    = 1'b1;
          pidx_d    = cnt_q[AW-1:0];
          cnt_d     = cnt_q + CW'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      cnt_q       <= '0;
      pidx_q      <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      cnt_q       <= cnt_d;
      pidx_q      <= pidx_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_load) begin
      kind_q   <= kind_i;
      key_q    <= key_i;
      name_q   <= name_text_i;
      amount_q <= amount_i;
      stamp_q  <= time_text_i;
    end
    status_q  <= status_d;
    res_rec_q <= res_rec_d;
    occ_q     <= occ_d;
    last_q    <= last_d;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign res_valid_o  = res_valid_q;
  assign status_o     = status_q;
  assign out_key_o    = res_rec_q.key;
  assign out_name_o   = res_rec_q.name;
  assign out_amount_o = res_rec_q.amount;
  assign out_time_o   = res_rec_q.stamp;
  assign occupancy_o  = occ_q;
  assign last_o       = last_q;

endmodule

[hw/rtl/krt_checker.sv]
// ----------------------------------------------------------------------------
// krt_port_props: port-level checks for the keyed record table
// Watches the command and result ports and flags results that break the
// table's rules.
// ----------------------------------------------------------------------------
module krt_port_props #(
  parameter int unsigned DEPTH = krt_pkg::DepthDefault
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic [krt_pkg::KindW-1:0]   kind_i,
  input logic [krt_pkg::KeyW-1:0]    key_i,
  input logic [krt_pkg::TextW-1:0]   name_text_i,
  input logic [krt_pkg::AmountW-1:0] amount_i,
  input logic [krt_pkg::TextW-1:0]   time_text_i,
  input logic                        res_valid_o,
  input logic [krt_pkg::StatusW-1:0] status_o,
  input logic [krt_pkg::KeyW-1:0]    out_key_o,
  input logic [krt_pkg::TextW-1:0]   out_name_o,
  input logic [krt_pkg::AmountW-1:0] out_amount_o,
  input logic [krt_pkg::TextW-1:0]   out_time_o,
  input logic [krt_pkg::OccW-1:0]    occupancy_o,
  input logic                        last_o
);

  logic refused;
  assign refused = res_valid_o && (status_o != krt_pkg::ST_OK);

  // A refused or missed request carries no record.
  a_refused_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    refused |-> (out_key_o == '0) && (out_name_o == '0) &&
                (out_amount_o == '0) && (out_time_o == '0))
    else $error("record fields not zero on a non-ok result");

  // A refused or missed request answers with a single, final result.
  a_refused_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    refused |-> last_o)
    else $error("non-ok result not marked last");

  // A full refusal only happens with the table at capacity.
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (status_o == krt_pkg::ST_FULL)) |->
      (occupancy_o == krt_pkg::OccW'(DEPTH)))
    else $error("full status with table below capacity");

  // More results of the same request follow, so no new request may enter.
  a_list_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !last_o) |-> busy_o)
    else $error("table idle in the middle of a listing");

  // Results only come from a request that was taken.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ($past(busy_o) || $past(start_i)))
    else $error("result without a request");

endmodule

bind keyed_record_table krt_port_props #(.DEPTH(DEPTH)) u_krt_port_props (.*);

[sim/krt_checker.sv]
// ----------------------------------------------------------------------------
// krt_checker: prediction and result checking for the keyed record table
// Watches the request and result channels, keeps its own copy of the table,
// works out the answers every accepted request must produce and compares the
// results that arrive, field by field and in order.
// ----------------------------------------------------------------------------
module krt_checker #(
  parameter int unsigned DEPTH = krt_pkg::DepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic [krt_pkg::KindW-1:0]   kind_i,
  input  logic [krt_pkg::KeyW-1:0]    key_i,
  input  logic [krt_pkg::TextW-1:0]   name_text_i,
  input  logic [krt_pkg::AmountW-1:0] amount_i,
  input  logic [krt_pkg::TextW-1:0]   time_text_i,
  input  logic                        res_valid_i,
  input  logic [krt_pkg::StatusW-1:0] status_i,
  input  logic [krt_pkg::KeyW-1:0]    out_key_i,
  input  logic [krt_pkg::TextW-1:0]   out_name_i,
  input  logic [krt_pkg::AmountW-1:0] out_amount_i,
  input  logic [krt_pkg::TextW-1:0]   out_time_i,
  input  logic [krt_pkg::OccW-1:0]    occupancy_i,
  input  logic                        last_i,
  output int unsigned                 mismatch_count_o,
  output int unsigned                 pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import krt_pkg::*;

  localparam int unsigned PrintCap = 40;

  typedef struct packed {
    status_e            status;
    rec_t               rec;
    logic [OccW-1:0]    occupancy;
    logic               last;
  } answer_t;

  rec_t        table_rec [DEPTH];
  int unsigned held_count;
  answer_t     answers_q [$];

  function automatic int locate_key(logic [KeyW-1:0] key);
    for (int i = 0; i < int'(held_count); i++) begin
      if (table_rec[i].key == key) return i;
    end
    return -1;
  endfunction

  // Any answer that is not a success carries an all-zero record.
  task automatic push_answer(status_e status, rec_t rec, logic fin);
    answer_t a;
    a.status    = status;
    a.rec       = (status == ST_OK) ? rec : '0;
    a.occupancy = OccW'(held_count);
    a.last      = fin;
    answers_q.push_back(a);
  endtask

  task automatic predict_request(logic [KindW-1:0] kind, rec_t req);
    int   slot;
    rec_t gone;
    slot = locate_key(req.key);
    case (kind)
      K_INSERT: begin
        // A full table is refused before the key is even looked at.
        if (held_count >= DEPTH) begin
          push_answer(ST_FULL, '0, 1'b1);
        end else if (slot >= 0) begin
          push_answer(ST_DUP, '0, 1'b1);
        end else begin
          table_rec[held_count] = req;
          held_count++;
          push_answer(ST_OK, req, 1'b1);
        end
      end
      K_SEARCH: begin
        if (slot < 0) push_answer(ST_MISS, '0, 1'b1);
        else push_answer(ST_OK, table_rec[slot], 1'b1);
      end
      K_UPDATE: begin
        if (slot < 0) begin
          push_answer(ST_MISS, '0, 1'b1);
        end else begin
          table_rec[slot].name   = req.name;
          table_rec[slot].amount = req.amount;
          table_rec[slot].stamp  = req.stamp;
          push_answer(ST_OK, table_rec[slot], 1'b1);
        end
      end
      K_DELETE: begin
        if (slot < 0) begin
          push_answer(ST_MISS, '0, 1'b1);
        end else begin
          // The removed record is returned with the count after removal.
          gone = table_rec[slot];
          for (int i = slot; i + 1 < int'(held_count); i++) begin
            table_rec[i] = table_rec[i + 1];
          end
          held_count--;
          push_answer(ST_OK, gone, 1'b1);
        end
      end
      K_LIST: begin
        if (held_count == 0) begin
          push_answer(ST_MISS, '0, 1'b1);
        end else begin
          for (int i = 0; i < int'(held_count); i++) begin
            push_answer(ST_OK, table_rec[i], (i + 1) == int'(held_count));
          end
        end
      end
      default: begin
        push_answer(ST_MISS, '0, 1'b1);
      end
    endcase
  endtask

  task automatic report_mismatch(string msg);
    if (mismatch_count_o < PrintCap) begin
      $display("[%0t] MISMATCH %s", $realtime, msg);
    end
    mismatch_count_o++;
  endtask

  task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h expected %h", field, got, want));
    end
  endtask

  task automatic check_result();
    answer_t want;
    if (answers_q.size() == 0) begin
      report_mismatch($sformatf("result with no request pending, status %0d key %h",
                                status_i, out_key_i));
    end else begin
      want = answers_q.pop_front();
      check_field("status", 64'(status_i), 64'(want.status));
      check_field("out_key", 64'(out_key_i), 64'(want.rec.key));
      check_field("out_name", out_name_i, want.rec.name);
      check_field("out_amount", 64'(out_amount_i), 64'(want.rec.amount));
      check_field("out_time", out_time_i, want.rec.stamp);
      check_field("occupancy", 64'(occupancy_i), 64'(want.occupancy));
      check_field("last", 64'(last_i), 64'(want.last));
    end
  endtask

  // The request is predicted before the result is checked, so a result that
  // lands on the edge where the next request is taken still meets the oldest
  // answer in the queue.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count       = 0;
      answers_q.delete();
      mismatch_count_o = 0;
      pending_count_o  = 0;
    end else begin
      if (start_i && !busy_i) begin
        predict_request(kind_i, {key_i, name_text_i, amount_i, time_text_i});
      end
      if ($isunknown(res_valid_i)) begin
        report_mismatch("result strobe is unknown");
      end else if (res_valid_i) begin
        check_result();
      end
      pending_count_o = answers_q.size();
    end
  end

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for the keyed record table
// Sends a directed set of requests covering every command, the extreme field
// values, duplicate and miss refusals, then rounds of random requests that
// fill, drain and churn the table. A checker beside the block predicts and
// compares every result; this module drives requests and prints the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import krt_pkg::*;

  // Unused command codes; the block must answer each with a miss.
  localparam logic [KindW-1:0] KindSpareLo  = 3'd5;
  localparam logic [KindW-1:0] KindSpareMid = 3'd6;
  localparam logic [KindW-1:0] KindSpareHi  = 3'd7;

  localparam int unsigned RandomItems = 450;
  localparam int unsigned KeyPoolSize = 40;
  localparam int unsigned RecentMax   = 64;
  // The slowest delete walks and shifts the full table.
  localparam int unsigned DrainCycles = 100;
  // Roughly 475 requests, each at worst a full delete or a full list plus a
  // long idle gap, stay well inside this limit, with ample margin.
  localparam int unsigned CycleLimit  = 500000;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_CHURN
  } mix_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [KindW-1:0]    kind_i;
  logic [KeyW-1:0]     key_i;
  logic [TextW-1:0]    name_text_i;
  logic [AmountW-1:0]  amount_i;
  logic [TextW-1:0]    time_text_i;
  logic                res_valid_o;
  logic [StatusW-1:0]  status_o;
  logic [KeyW-1:0]     out_key_o;
  logic [TextW-1:0]    out_name_o;
  logic [AmountW-1:0]  out_amount_o;
  logic [TextW-1:0]    out_time_o;
  logic [OccW-1:0]     occupancy_o;
  logic                last_o;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned cycle_count = 0;

  // Keys handed out by the stimulus: a fixed pool so that searches, updates
  // and deletes hit often, plus the keys of recent inserts.
  logic [KeyW-1:0] key_pool [KeyPoolSize];
  logic [KeyW-1:0] recent_keys [$];

  keyed_record_table u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .kind_i       (kind_i),
    .key_i        (key_i),
    .name_text_i  (name_text_i),
    .amount_i     (amount_i),
    .time_text_i  (time_text_i),
    .res_valid_o  (res_valid_o),
    .status_o     (status_o),
    .out_key_o    (out_key_o),
    .out_name_o   (out_name_o),
    .out_amount_o (out_amount_o),
    .out_time_o   (out_time_o),
    .occupancy_o  (occupancy_o),
    .last_o       (last_o)
  );

  krt_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .kind_i           (kind_i),
    .key_i            (key_i),
    .name_text_i      (name_text_i),
    .amount_i         (amount_i),
    .time_text_i      (time_text_i),
    .res_valid_i      (res_valid_o),
    .status_i         (status_o),
    .out_key_i        (out_key_o),
    .out_name_i       (out_name_o),
    .out_amount_i     (out_amount_o),
    .out_time_i       (out_time_o),
    .occupancy_i      (occupancy_o),
    .last_i           (last_o),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("keyed_record_table verification failed");
      $finish;
    end
  end

  // Most gaps are zero or short, a few are long. In a calm round the
  // requests go back to back, with start held high across busy periods.
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Text fields are mostly random, with the all-zero and all-one patterns
  // mixed in so that every bit sees both values in both extremes.
  function automatic logic [TextW-1:0] pick_text();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [AmountW-1:0] pick_amount();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return AmountW'($urandom);
  endfunction

  // fresh_pct is the chance of a brand-new random key; the rest is split
  // between recently inserted keys and the fixed pool.
  function automatic logic [KeyW-1:0] pick_key(int unsigned fresh_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < fresh_pct) return KeyW'($urandom);
    if (recent_keys.size() != 0 && r < fresh_pct + (100 - fresh_pct) / 2) begin
      return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    end
    return key_pool[$urandom_range(0, KeyPoolSize - 1)];
  endfunction

  function automatic logic [KindW-1:0] pick_kind(mix_e mix);
    int unsigned r;
    r = $urandom_range(0, 99);
    // A small share of unused codes as noise, and occasional full listings.
    if (r < 3) return KindW'($urandom_range(KindSpareLo, KindSpareHi));
    if (r < 9) return K_LIST;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 75) return K_INSERT;
        if (r < 85) return K_SEARCH;
        if (r < 93) return K_UPDATE;
        return K_DELETE;
      end
      MIX_DRAIN: begin
        if (r < 15) return K_INSERT;
        if (r < 35) return K_SEARCH;
        if (r < 50) return K_UPDATE;
        return K_DELETE;
      end
      default: begin
        if (r < 25) return K_INSERT;
        if (r < 50) return K_SEARCH;
        if (r < 75) return K_UPDATE;
        return K_DELETE;
      end
    endcase
  endfunction

  // Presents one request and holds it until the block takes it. With a zero
  // gap start simply stays high and the next request's fields follow on the
  // same edge, so start is never lowered and raised within one time step.
  task automatic send_request(logic [KindW-1:0] kind, logic [KeyW-1:0] key,
                              logic [TextW-1:0] name, logic [AmountW-1:0] amount,
                              logic [TextW-1:0] stamp, int unsigned gap);
    start_i     <= 1'b1;
    kind_i      <= kind;
    key_i       <= key;
    name_text_i <= name;
    amount_i    <= amount;
    time_text_i <= stamp;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (kind == K_INSERT) begin
      recent_keys.push_back(key);
      if (recent_keys.size() > RecentMax) void'(recent_keys.pop_front());
    end
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random(mix_e mix, bit calm);
    logic [KindW-1:0] kind;
    int unsigned      fresh_pct;
    kind = pick_kind(mix);
    if (kind == K_INSERT) fresh_pct = (mix == MIX_FILL) ? 50 : 20;
    else fresh_pct = 10;
    send_request(kind, pick_key(fresh_pct), pick_text(), pick_amount(), pick_text(),
                 pick_gap(calm));
  endtask

  initial begin
    mix_e        mix;
    bit          calm;
    int unsigned round_len;
    int unsigned sent;

    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    kind_i      <= K_INSERT;
    key_i       <= '0;
    name_text_i <= '0;
    amount_i    <= '0;
    time_text_i <= '0;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KeyPoolSize; i++) key_pool[i] = KeyW'($urandom);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. An empty table answers every lookup and the listing with
    // a miss, and unused codes are answered with a miss as well.
    send_request(K_LIST, '0, '0, '0, '0, pick_gap(1'b0));
    send_request(K_SEARCH, '0, '0, '0, '0, pick_gap(1'b0));
    send_request(K_UPDATE, '1, '1, '1, '1, pick_gap(1'b0));
    send_request(K_DELETE, '0, '0, '0, '0, pick_gap(1'b0));
    send_request(KindSpareLo, '1, '1, '1, '1, pick_gap(1'b0));
    send_request(KindSpareHi, '0, '0, '0, '0, pick_gap(1'b0));
    // Records at both extremes, then a duplicate key refused.
    send_request(K_INSERT, '0, '0, '0, '0, 0);
    send_request(K_INSERT, '1, '1, '1, '1, 0);
    send_request(K_INSERT, '0, '1, '1, '1, pick_gap(1'b0));
    send_request(K_SEARCH, '1, '0, '0, '0, 0);
    send_request(K_SEARCH, '0, '0, '0, '0, 0);
    // Updates swap the payload extremes, a miss on a key never stored.
    send_request(K_UPDATE, '0, '1, '1, '1, 0);
    send_request(K_UPDATE, '1, '0, '0, '0, pick_gap(1'b0));
    send_request(K_UPDATE, 16'h1234, '1, '1, '1, 0);
    send_request(K_LIST, '0, '0, '0, '0, pick_gap(1'b0));
    send_request(K_INSERT, 16'h1234, 64'hA5A5_5A5A_0F0F_F0F0, 16'h5AA5,
                 64'h3030_3A35_393A_3539, 0);
    // Delete at the front shifts the rest down, delete at the tail does not.
    send_request(K_DELETE, '0, '0, '0, '0, 0);
    send_request(K_LIST, '0, '0, '0, '0, 0);
    send_request(K_DELETE, 16'h1234, '0, '0, '0, pick_gap(1'b0));
    send_request(K_DELETE, '0, '1, '1, '1, 0);
    send_request(K_LIST, '0, '0, '0, '0, 0);
    send_request(K_DELETE, '1, '0, '0, '0, 0);
    send_request(K_LIST, '0, '0, '0, '0, pick_gap(1'b0));
    send_request(KindSpareMid, '0, '0, '0, '0, 0);

    // Random part in rounds. The first round fills the table well past its
    // capacity so that full refusals, including ones whose key is already
    // present, come early; later rounds pick a fill, drain or churn mix.
    sent = 0;
    while (sent < RandomItems) begin
      if (sent == 0) begin
        mix       = MIX_FILL;
        round_len = 50;
      end else begin
        mix       = mix_e'($urandom_range(0, 2));
        round_len = $urandom_range(10, 40);
      end
      calm = ($urandom_range(0, 3) == 0);
      repeat (round_len) begin
        send_random(mix, calm);
        sent++;
      end
    end

    // Let every outstanding result arrive, then a quiet stretch to catch any
    // stray results before the verdict.
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("keyed_record_table verification clean");
    end else begin
      $display("keyed_record_table verification failed");
    end
    $finish;
  end

endmodule
